>>> design/stip_pkg.sv
// ----------------------------------------------------------------------------
// stip_pkg
// Shared constants and types of the string to integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_LEN     = 4095;

    localparam int CH_W    = 8;
    localparam int VAL_W   = 64;
    localparam int OFFS_W  = 12;
    localparam int RADIX_W = 6;
    localparam int DIG_W   = 6;
    localparam int POS_W   = $clog2(MAX_LEN + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RADIX_W;

    localparam int OUT_W   = ((VAL_W + 1 + OFFS_W + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - VAL_W - 1 - OFFS_W;

    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    localparam logic [DIG_W-1:0] D_NONE = '1;

    localparam logic [VAL_W-1:0] SMAX =
        {{(VAL_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic [VAL_W-1:0] SMIN = ~SMAX;

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic             blank;
        logic             sign;
        logic             minus;
        logic             zero;
        logic             xch;
        logic             nul;
        logic             last;
    } t_cls;

endpackage

>>> design/stip_front.sv
// ----------------------------------------------------------------------------
// stip_front
// Accepts characters and classifies them for the queue.
// ----------------------------------------------------------------------------
module stip_front (
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [stip_pkg::CH_W-1:0] i_ch,
    input  logic                      i_last,
    input  logic                      i_q_full,
    output logic                      o_push,
    output stip_pkg::t_cls            o_item
);
    import stip_pkg::*;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

    function automatic logic [DIG_W-1:0] f_digit(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] d;
        d = '1;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA + LETTER_OFS;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + LETTER_OFS;
        end
        return (d == '1) ? D_NONE : DIG_W'(d);
    endfunction

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item.digit = f_digit(i_ch);
        o_item.nul   = (i_ch == CH_NUL);
        o_item.blank = (i_ch == CH_NUL) || (i_ch == CH_SPACE) ||
                       (i_ch >= CH_TAB && i_ch <= CH_CR);
        o_item.sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
        o_item.minus = (i_ch == CH_MINUS);
        o_item.zero  = (i_ch == CH_0);
        o_item.xch   = (i_ch == CH_LX) || (i_ch == CH_UX);
        o_item.last  = i_last;
    end

endmodule

>>> design/stip_queue.sv
// ----------------------------------------------------------------------------
// stip_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module stip_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stip_pkg::t_cls i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output stip_pkg::t_cls o_item
);
    import stip_pkg::*;

    t_cls            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/stip_back.sv
// ----------------------------------------------------------------------------
// stip_back
// Scan state machine, base-times-value accumulation and result forming.
// ----------------------------------------------------------------------------
module stip_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [stip_pkg::RADIX_W-1:0] i_radix,
    input  logic                         i_unsigned,
    input  logic                         i_q_valid,
    input  stip_pkg::t_cls               i_q_item,
    output logic                         o_q_pop,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [stip_pkg::OUT_W-1:0]   o_m_tdata
);
    import stip_pkg::*;

    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_XPEND  = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;

    localparam int PROD_W = VAL_W + RADIX_W;

    logic [2:0]         r_phase, n_phase;
    logic [VAL_W-1:0]   r_acc,   n_acc;
    logic               r_ovf,   n_ovf;
    logic               r_neg,   n_neg;
    logic [RADIX_W-1:0] r_base,  n_base;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_stop,  n_stop;
    logic [POS_W-1:0]   pos_nx;

    logic               first, zpre, take, digit_ok;
    logic [RADIX_W-1:0] tb;
    logic [PROD_W-1:0]  prod;

    logic               r_fin_vld;
    logic [VAL_W-1:0]   r_fin_acc;
    logic               r_fin_ovf;
    logic               r_fin_neg;
    logic [POS_W-1:0]   r_fin_stop;
    logic               out_free, fin_free, fin_move;

    logic               r_out_vld;
    logic [OUT_W-1:0]   r_out_data;
    logic [VAL_W-1:0]   res_val;
    logic               res_err;
    logic               big;

    assign out_free = !r_out_vld || i_m_tready;
    assign fin_move = r_fin_vld && out_free;
    assign fin_free = !r_fin_vld || out_free;
    assign o_q_pop  = i_q_valid && (!i_q_item.last || fin_free);

    assign pos_nx = (r_pos >= POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN) : r_pos + 1'b1;

    // path select: which base goes to the multiplier
    always_comb begin
        first = 1'b0;
        zpre  = 1'b0;
        take  = 1'b0;
        tb    = r_base;
        unique case (r_phase)
            PH_SKIP:   first = !i_q_item.blank && !i_q_item.sign;
            PH_START:  first = 1'b1;
            PH_ZERO: begin
                take = !i_q_item.xch;
                tb   = (r_base == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
            end
            PH_XPEND: begin
                take = !i_q_item.nul;
                tb   = BASE_HEX;
            end
            PH_DIGITS: take = 1'b1;
            default:   take = 1'b0;
        endcase
        if (first) begin
            if ((i_radix == RADIX_AUTO || i_radix == BASE_HEX) && i_q_item.zero) begin
                zpre = 1'b1;
            end else begin
                tb   = (i_radix == RADIX_AUTO) ? BASE_DEC : i_radix;
                take = 1'b1;
            end
        end
    end

    assign digit_ok = (tb >= BASE_MIN) && (tb <= BASE_MAX) && (i_q_item.digit < tb);
    assign prod     = PROD_W'(r_acc) * PROD_W'(tb) + PROD_W'(i_q_item.digit);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_neg   = r_neg;
        n_base  = r_base;
        n_stop  = r_stop;
        unique case (r_phase)
            PH_SKIP: begin
                if (!i_q_item.blank && i_q_item.sign) begin
                    n_neg   = i_q_item.minus;
                    n_stop  = pos_nx;
                    n_phase = PH_START;
                end
            end
            PH_ZERO: begin
                if (i_q_item.xch) begin
                    n_phase = PH_XPEND;
                end
            end
            PH_XPEND: begin
                if (i_q_item.nul) begin
                    n_phase = PH_DONE;
                end else begin
                    n_stop = r_pos;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        if (zpre) begin
            n_stop  = pos_nx;
            n_base  = i_radix;
            n_phase = PH_ZERO;
        end
        if (take) begin
            n_base = tb;
            if (!digit_ok) begin
                n_phase = PH_DONE;
            end else begin
                if (!r_ovf) begin
                    if (prod[PROD_W-1:VAL_W] != '0) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = prod[VAL_W-1:0];
                    end
                end
                n_stop  = pos_nx;
                n_phase = PH_DIGITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_pos   <= '0;
            r_stop  <= '0;
        end else if (o_q_pop) begin
            if (i_q_item.last) begin
                r_phase <= PH_SKIP;
                r_acc   <= '0;
                r_ovf   <= 1'b0;
                r_neg   <= 1'b0;
                r_base  <= '0;
                r_pos   <= '0;
                r_stop  <= '0;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_pos   <= pos_nx;
                r_stop  <= n_stop;
            end
        end
    end

    // finished string, waiting for saturation and sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (o_q_pop && i_q_item.last) begin
            r_fin_vld <= 1'b1;
        end else if (fin_move) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.last) begin
            r_fin_acc  <= n_acc;
            r_fin_ovf  <= n_ovf;
            r_fin_neg  <= n_neg;
            r_fin_stop <= n_stop;
        end
    end

    always_comb begin
        big     = r_fin_ovf || (r_fin_acc > SMAX);
        res_err = 1'b0;
        if (i_unsigned) begin
            if (r_fin_neg) begin
                res_val = '0;
                res_err = 1'b1;
            end else if (big) begin
                res_val = SMAX;
                res_err = 1'b1;
            end else begin
                res_val = r_fin_acc;
            end
        end else begin
            if (big) begin
                res_val = r_fin_neg ? SMIN : SMAX;
                res_err = 1'b1;
            end else begin
                res_val = r_fin_neg ? (~r_fin_acc + 1'b1) : r_fin_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_move) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out_data <= {{OUT_PAD{1'b0}}, OFFS_W'(r_fin_stop), res_err, res_val};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

>>> design/string_to_integer_parser_core.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser_core
// Character stream to integer conversion with base detection and saturation.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, set by the single base-times-value
//   accumulate step in the back end, while the queue is not full and results drain.
// Path: a last character passes through the queue, the finished-string
//   register and the result register before its result is valid.
// Reset: synchronous, active low; clears queue and scan state, radix 10,
//   signed mode.
module string_to_integer_parser_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [stip_pkg::CH_W-1:0]       s_axis_tdata,   // [7:0] ch
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [stip_pkg::OUT_W-1:0]      m_axis_tdata,   // [63:0] value,
                                                            // [64] range_error,
                                                            // [76:65] end_offset
    input  logic                            i_cfg_we,
    input  logic [stip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stip_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import stip_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED = 1'd1;
    localparam logic [RADIX_W-1:0]   RADIX_RESET  = 6'd10;

    logic [RADIX_W-1:0] r_radix;
    logic               r_unsigned;

    t_cls front_item, q_item;
    logic q_full, q_push, q_pop, q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= RADIX_RESET;
            r_unsigned <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIX:    r_radix    <= i_cfg_wdata[RADIX_W-1:0];
                CFG_UNSIGNED: r_unsigned <= i_cfg_wdata[0];
                default:      r_unsigned <= r_unsigned;
            endcase
        end
    end

    stip_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_ch     (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    stip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    stip_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_radix    (r_radix),
        .i_unsigned (r_unsigned),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

>>> design/stip_checker.sv
// ----------------------------------------------------------------------------
// stip_checker
// Port-level checks of the string to integer parser, bound to the top level.
// ----------------------------------------------------------------------------
module stip_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [stip_pkg::OUT_W-1:0]      m_axis_tdata
);
    import stip_pkg::*;

    logic [VAL_W-1:0]  val;
    logic              err;
    logic [OFFS_W-1:0] offs;

    assign val  = m_axis_tdata[VAL_W-1:0];
    assign err  = m_axis_tdata[VAL_W];
    assign offs = m_axis_tdata[VAL_W+OFFS_W:VAL_W+1];

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_err_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && err |-> val == SMAX || val == SMIN || val == '0)
        else $error("range error without saturated value");

    a_empty_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && offs == '0 |-> val == '0 && !err)
        else $error("nonzero result with nothing scanned");

endmodule

bind string_to_integer_parser_core stip_checker u_stip_checker (.*);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for string_to_integer_parser_core.
// Strings are fed one character per item. Directed strings come first:
// blanks, signs, base prefixes, the limits of the 64-bit range, bytes above
// 127 and odd radix values. Random phases follow, each with its own radix,
// signed or unsigned mode and idle pattern. A scoreboard predicts each
// result and compares it field by field with the result stream.
// ----------------------------------------------------------------------------
module testbench;
    import stip_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASE_CHARS     = 112;
    localparam int NUM_PHASES      = 14;
    localparam int MAX_REPORTS     = 10;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED = 1'd1;

    typedef enum logic [2:0] {
        SCAN_BLANKS,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_XPEND,
        SCAN_DIGITS,
        SCAN_DONE
    } t_scan;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic              range_err;
        logic [OFFS_W-1:0] offset;
    } t_parse_result;

    class t_parse_scoreboard;
        logic [RADIX_W-1:0] radix    = 6'd10;
        logic               uns_mode = 1'b0;
        t_scan              scan     = SCAN_BLANKS;
        logic [VAL_W-1:0]   acc      = '0;
        logic               ovf      = 1'b0;
        logic               neg      = 1'b0;
        logic [RADIX_W-1:0] base     = '0;
        int                 pos      = 0;
        int                 stop     = 0;
        t_parse_result      expected_q[$];
        int                 mismatches   = 0;
        int                 strings      = 0;
        int                 chars        = 0;
        int                 results      = 0;
        int                 range_errors = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_RADIX) begin
                radix = data;
            end else if (idx == REG_UNSIGNED) begin
                uns_mode = data[0];
            end
        endfunction

        function int sat_inc(int p);
            return (p >= MAX_LEN) ? MAX_LEN : p + 1;
        endfunction

        function void clear_scan();
            scan = SCAN_BLANKS;
            acc  = '0;
            ovf  = 1'b0;
            neg  = 1'b0;
            base = '0;
            pos  = 0;
            stop = 0;
        endfunction

        function void take_digit(logic [7:0] ch);
            int d;
            logic [127:0] wide;
            if (ch >= "0" && ch <= "9") begin
                d = ch - "0";
            end else if (ch >= "A" && ch <= "Z") begin
                d = ch - "A" + 10;
            end else if (ch >= "a" && ch <= "z") begin
                d = ch - "a" + 10;
            end else begin
                d = 99;
            end
            if (base < 2 || base > 36 || d >= base) begin
                scan = SCAN_DONE;
                return;
            end
            if (!ovf) begin
                wide = 128'(acc) * 128'(base) + 128'(d);
                if (wide[127:64] != 0) begin
                    ovf = 1'b1;
                end else begin
                    acc = wide[63:0];
                end
            end
            stop = sat_inc(pos);
            scan = SCAN_DIGITS;
        endfunction

        // a leading zero may open a prefix when the base is detected or hex
        function void first_digit(logic [7:0] ch);
            if ((radix == 0 || radix == 16) && ch == "0") begin
                acc  = '0;
                stop = sat_inc(pos);
                base = radix;
                scan = SCAN_ZERO;
                return;
            end
            base = (radix == 0) ? 6'd10 : radix;
            take_digit(ch);
        endfunction

        function void note_char(logic [7:0] ch, logic last);
            t_parse_result r;
            logic blank;
            chars++;
            blank = (ch == 8'h00) || (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
            case (scan)
                SCAN_BLANKS: begin
                    if (!blank) begin
                        if (ch == "+" || ch == "-") begin
                            neg  = (ch == "-");
                            stop = sat_inc(pos);
                            scan = SCAN_SIGN;
                        end else begin
                            first_digit(ch);
                        end
                    end
                end
                SCAN_SIGN: begin
                    first_digit(ch);
                end
                SCAN_ZERO: begin
                    if (ch == "x" || ch == "X") begin
                        scan = SCAN_XPEND;
                    end else begin
                        base = (base == 0) ? 6'd8 : 6'd16;
                        take_digit(ch);
                    end
                end
                SCAN_XPEND: begin
                    if (ch == 8'h00) begin
                        scan = SCAN_DONE;
                    end else begin
                        base = 6'd16;
                        acc  = '0;
                        stop = pos;
                        take_digit(ch);
                    end
                end
                SCAN_DIGITS: begin
                    take_digit(ch);
                end
                default: begin
                end
            endcase
            pos = sat_inc(pos);
            if (!last) return;

            r.range_err = 1'b0;
            if (uns_mode) begin
                if (neg) begin
                    r.value     = '0;
                    r.range_err = 1'b1;
                end else if (ovf || acc > SMAX) begin
                    r.value     = SMAX;
                    r.range_err = 1'b1;
                end else begin
                    r.value = acc;
                end
            end else begin
                if (ovf || acc > SMAX) begin
                    r.value     = neg ? SMIN : SMAX;
                    r.range_err = 1'b1;
                end else begin
                    r.value = neg ? -acc : acc;
                end
            end
            r.offset = stop[OFFS_W-1:0];
            expected_q.push_back(r);
            strings++;
            clear_scan();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            t_parse_result got;
            t_parse_result want;
            got.value     = data[VAL_W-1:0];
            got.range_err = data[VAL_W];
            got.offset    = data[VAL_W+1 +: OFFS_W];
            results++;
            if (got.range_err === 1'b1) range_errors++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result %0d with no string pending: value=%h err=%0b offset=%0d",
                             results, got.value, got.range_err, got.offset);
                return;
            end
            want = expected_q.pop_front();
            if (got.value !== want.value || got.range_err !== want.range_err ||
                    got.offset !== want.offset) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result %0d: expected value=%h err=%0b offset=%0d, ",
                              "got value=%h err=%0b offset=%0d"},
                             results, want.value, want.range_err, want.offset,
                             got.value, got.range_err, got.offset);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CH_W-1:0]       s_axis_tdata = '0;    // [7:0] ch
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // [63:0] value, [64] range_error,
                                                 // [76:65] end_offset
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    t_parse_scoreboard sb;
    logic [7:0]      str_buf[$];
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              hold_left      = 0;
    int              settings       = 0;
    int              cycle_count    = 0;

    logic [7:0]  blank_set [7]           = '{8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
    int unsigned radix_plan [NUM_PHASES] = '{10, 0, 16, 2, 8, 36, 0, 10, 16, 1, 37, 63, 7, 0};
    logic        uns_plan [NUM_PHASES]   = '{0, 0, 1, 1, 0, 1, 1, 0, 0, 1, 0, 1, 0, 1};

    string_to_integer_parser_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: long hold-off on request, otherwise random stalls
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_char(ch, last);
        @(negedge i_clk);
    endtask

    task automatic send_buf();
        int n;
        n = str_buf.size();
        for (int i = 0; i < n; i++) send_char(str_buf[i], i == n - 1);
        str_buf.delete();
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    endfunction

    task automatic send_text(string s);
        push_text(s);
        send_buf();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned radix, input logic uns);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_RADIX;
        i_cfg_wdata <= CFG_DATA_W'(radix);
        @(negedge i_clk);
        i_cfg_index <= REG_UNSIGNED;
        i_cfg_wdata <= CFG_DATA_W'(uns);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(REG_RADIX, CFG_DATA_W'(radix));
        sb.write_reg(REG_UNSIGNED, CFG_DATA_W'(uns));
        settings++;
    endtask

    task automatic start_phase(input int unsigned radix, input logic uns,
                               input int send_pct, input int recv_pct);
        drain();
        set_config(radix, uns);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // mostly well-formed numbers with random blanks, sign, prefix and tail
    task automatic send_random_string();
        int r;
        int nd;
        int dv;
        int base_d;
        if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(1, 6)) str_buf.push_back(8'($urandom_range(255)));
            send_buf();
            return;
        end
        repeat ($urandom_range(0, 2)) str_buf.push_back(blank_set[$urandom_range(6)]);
        case ($urandom_range(3))
            0: str_buf.push_back("+");
            1: str_buf.push_back("-");
            default: begin
            end
        endcase
        base_d = sb.radix;
        if (sb.radix == 0 || sb.radix == 16) begin
            r = $urandom_range(3);
            if (r == 0) begin
                str_buf.push_back("0");
                str_buf.push_back($urandom_range(1) ? "x" : "X");
                base_d = 16;
            end else if (r == 1 && sb.radix == 0) begin
                str_buf.push_back("0");
                base_d = 8;
            end else begin
                base_d = (sb.radix == 0) ? 10 : 16;
            end
        end else if (sb.radix < 2 || sb.radix > 36) begin
            base_d = 36;
        end
        r  = $urandom_range(9);
        nd = (r == 0) ? 0 :
             (r < 6)  ? $urandom_range(1, 6) :
             (r < 9)  ? $urandom_range(7, 22) : $urandom_range(23, 70);
        repeat (nd) begin
            dv = $urandom_range(base_d - 1);
            if (dv < 10)
                str_buf.push_back(8'("0" + dv));
            else
                str_buf.push_back($urandom_range(1) ? 8'("a" + dv - 10) : 8'("A" + dv - 10));
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) str_buf.push_back(8'($urandom_range(255)));
        if (str_buf.size() == 0) str_buf.push_back(blank_set[$urandom_range(6)]);
        send_buf();
    endtask

    initial begin
        int start_chars;
        int mode;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        start_phase(10, 1'b0, 0, 0);
        send_text(" ");
        send_text(" \t-42");
        send_text("+");
        send_text("-");
        send_text("9223372036854775807");
        send_text("-9223372036854775808");
        send_text("9223372036854775808");
        send_text("18446744073709551616");
        send_text("12ab");
        str_buf.push_back(8'hB5);
        push_text("7");
        send_buf();
        push_text("12");
        str_buf.push_back(8'h00);
        push_text("3");
        send_buf();

        start_phase(0, 1'b0, 0, 0);
        send_text("0x1F");
        send_text("0x");
        push_text("0x");
        str_buf.push_back(8'h00);
        send_buf();
        send_text("0xg");
        send_text("017");
        send_text("0");
        send_text("-0x8000000000000000");

        start_phase(16, 1'b1, 0, 0);
        send_text("0Xff");
        send_text("-1");
        send_text("ffffffffffffffff");

        start_phase(36, 1'b1, 0, 0);
        send_text("zZ");
        start_phase(2, 1'b0, 0, 0);
        send_text("102");
        start_phase(1, 1'b0, 0, 0);
        send_text("5");
        start_phase(63, 1'b1, 0, 0);
        send_text("z");

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            mode = ph % 4;
            start_phase(radix_plan[ph], uns_plan[ph],
                        (mode == 1) ? 87 : (mode == 3) ? 29 : 0,
                        (mode == 2) ? 87 : (mode == 3) ? 29 : 0);
            if (ph == 4) hold_left = HOLD_OFF_CYCLES;
            start_chars = sb.chars;
            while (sb.chars - start_chars < PHASE_CHARS) begin
                if ($urandom_range(29) == 0) drain();
                send_random_string();
            end
        end

        drain();
        $display("Summary: %0d strings in %0d characters over %0d radix/mode settings,",
                 sb.strings, sb.chars, settings);
        $display("         %0d results checked, %0d with range error, %0d mismatches.",
                 sb.results, sb.range_errors, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
